FILE: rtl/icf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icf_pkg
// Shared constants and the arctangent table for the complementary filter.
// ----------------------------------------------------------------------------
package icf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_IW    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    localparam int TILT_W  = 20;   // signed Q4.16 tilt angle, |angle| < 2 rad
    localparam int CORD_W  = 28;   // signed CORDIC x/y datapath
    localparam int ANGLE_W = 32;

    localparam logic [15:0] BLEND_RESET = 16'd62915;

    // Arctangent of 2^-i in signed Q4.16, rounded to nearest.
    function automatic logic signed [TILT_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [TILT_W-1:0] v;
        begin
            unique case (idx)
                5'd0:    v = 20'sd51472;
                5'd1:    v = 20'sd30386;
                5'd2:    v = 20'sd16055;
                5'd3:    v = 20'sd8150;
                5'd4:    v = 20'sd4091;
                5'd5:    v = 20'sd2047;
                5'd6:    v = 20'sd1024;
                5'd7:    v = 20'sd512;
                5'd8:    v = 20'sd256;
                5'd9:    v = 20'sd128;
                5'd10:   v = 20'sd64;
                5'd11:   v = 20'sd32;
                5'd12:   v = 20'sd16;
                5'd13:   v = 20'sd8;
                5'd14:   v = 20'sd4;
                5'd15:   v = 20'sd2;
                5'd16:   v = 20'sd1;
                default: v = 20'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: rtl/imu_complementary_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_complementary_filter_core
// Roll/pitch/yaw complementary filter over a stream of IMU samples.
// ----------------------------------------------------------------------------
// Each input item is one IMU sample and produces exactly one result item with
// the updated roll, pitch and yaw angles in signed Q16.16 radians. After
// acceptance the r_start register starts all lanes. Each tilt lane runs a
// bit-serial square root and then 16 CORDIC steps. The three gyro integration
// lanes run side by side with them, dividing by 15625 with three folding steps
// and a reciprocal multiply. Once all lanes are done, ST_RUN notices it, the
// ST_MUL and ST_SUM states merge the lanes, and ST_PUSH moves the result into
// the output register once that is free. One item is processed at a time, and
// a new item is taken as soon as the previous result has moved into the output
// register, even while that result still waits for the downstream side. The
// blend weight is written through i_cfg_wr_en/i_cfg_wr_data and should only
// change while the block is idle. The first sample after reset measures its
// time step from timestamp 0.
// ----------------------------------------------------------------------------
module imu_complementary_filter_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0 up: timestamp_us[31:0], accel_x, accel_y, accel_z,
    // gyro_x, gyro_y, gyro_z (16 bits each).
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0 up: roll_out, pitch_out, yaw_out (32 bits each).
    output logic [95:0]  m_axis_tdata
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RUN  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_SUM  = 5'b01000,
        ST_PUSH = 5'b10000
    } t_core_state;

    t_core_state r_state, n_state;

    logic [15:0] r_weight;
    logic [31:0] r_last_time, r_dt;
    logic [31:0] r_roll, r_pitch, r_yaw;
    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy, r_gz;
    logic r_start;
    logic signed [48:0] r_roll_pg, r_pitch_pg;
    logic signed [37:0] r_roll_pt, r_pitch_pt;
    logic [95:0] r_out;
    logic r_out_valid;

    logic w_accept, w_out_free, w_all_done;
    logic w_roll_done, w_pitch_done, w_rg_done, w_pg_done, w_yg_done;
    logic signed [icf_pkg::TILT_W-1:0] w_roll_tilt, w_pitch_tilt;
    logic [31:0] w_roll_gyro, w_pitch_gyro, w_yaw_gyro;
    logic signed [16:0] w_w, w_neg_ay;
    logic signed [17:0] w_wc;
    logic signed [49:0] w_roll_sum, w_pitch_sum;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_all_done    = w_roll_done && w_pitch_done && w_rg_done && w_pg_done
                           && w_yg_done;
    assign w_neg_ay      = 17'sd0 - 17'(r_ay);

    // Tilt lanes: roll from accel_x over (y, z), pitch from -accel_y over (x, z).
    icf_tilt_lane u_roll_tilt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   (17'(r_ax)),
        .i_a     (r_ay),
        .i_b     (r_az),
        .o_done  (w_roll_done),
        .o_tilt  (w_roll_tilt)
    );

    icf_tilt_lane u_pitch_tilt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   (w_neg_ay),
        .i_a     (r_ax),
        .i_b     (r_az),
        .o_done  (w_pitch_done),
        .o_tilt  (w_pitch_tilt)
    );

    // Gyro lanes: roll integrates gyro_y, pitch gyro_x, yaw gyro_z.
    icf_gyro_lane u_roll_gyro (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_rate  (r_gy),
        .i_dt    (r_dt),
        .i_angle (r_roll),
        .o_done  (w_rg_done),
        .o_angle (w_roll_gyro)
    );

    icf_gyro_lane u_pitch_gyro (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_rate  (r_gx),
        .i_dt    (r_dt),
        .i_angle (r_pitch),
        .o_done  (w_pg_done),
        .o_angle (w_pitch_gyro)
    );

    icf_gyro_lane u_yaw_gyro (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_rate  (r_gz),
        .i_dt    (r_dt),
        .i_angle (r_yaw),
        .o_done  (w_yg_done),
        .o_angle (w_yaw_gyro)
    );

    // Merge stage: w * gyro + (1 - w) * tilt, rounded and floored to Q16.16.
    // The tilt weight reaches 65536 when w is zero, hence the extra bit.
    assign w_w  = signed'({1'b0, r_weight});
    assign w_wc = 18'sd65536 - 18'(w_w);

    assign w_roll_sum  = 50'(r_roll_pg) + 50'(r_roll_pt) + 50'sd32768;
    assign w_pitch_sum = 50'(r_pitch_pg) + 50'(r_pitch_pt) + 50'sd32768;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_RUN;
            ST_RUN:  if (!r_start && w_all_done) n_state = ST_MUL;
            ST_MUL:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_PUSH;
            ST_PUSH: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_weight    <= icf_pkg::BLEND_RESET;
            r_last_time <= '0;
            r_roll      <= '0;
            r_pitch     <= '0;
            r_yaw       <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_accept;
            if (i_cfg_wr_en) begin
                r_weight <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_last_time <= s_axis_tdata[31:0];
            end
            if (r_state == ST_SUM) begin
                r_roll  <= w_roll_sum[47:16];
                r_pitch <= w_pitch_sum[47:16];
                r_yaw   <= w_yaw_gyro;
            end
            if (r_state == ST_PUSH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dt <= s_axis_tdata[31:0] - r_last_time;
            r_ax <= signed'(s_axis_tdata[47:32]);
            r_ay <= signed'(s_axis_tdata[63:48]);
            r_az <= signed'(s_axis_tdata[79:64]);
            r_gx <= signed'(s_axis_tdata[95:80]);
            r_gy <= signed'(s_axis_tdata[111:96]);
            r_gz <= signed'(s_axis_tdata[127:112]);
        end
        if (r_state == ST_MUL) begin
            r_roll_pg  <= w_w * signed'(w_roll_gyro);
            r_pitch_pg <= w_w * signed'(w_pitch_gyro);
            r_roll_pt  <= w_wc * w_roll_tilt;
            r_pitch_pt <= w_wc * w_pitch_tilt;
        end
        if (r_state == ST_PUSH && w_out_free) begin
            r_out <= {r_yaw, r_pitch, r_roll};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_start && r_state == ST_RUN))
        else $error("accepted item did not start the lanes");

    a_lanes_before_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> w_all_done)
        else $error("merge stage entered before all lanes finished");

    a_push_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH && w_out_free) |=> (m_axis_tvalid && r_state == ST_IDLE))
        else $error("result not moved into the output register");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN || r_state == ST_SUM) |-> !s_axis_tready)
        else $error("input ready while an item is in flight");
`endif

endmodule

FILE: rtl/icf_tilt_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icf_tilt_lane
// Tilt angle atan2(num, sqrt(a^2 + b^2)) by a bit-serial square root followed
// by iterative CORDIC vectoring.
// ----------------------------------------------------------------------------
module icf_tilt_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [16:0]                  i_num,
    input  logic signed [15:0]                  i_a,
    input  logic signed [15:0]                  i_b,
    output logic                                o_done,
    output logic signed [icf_pkg::TILT_W-1:0]   o_tilt
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SQRT = 4'b0010,
        ST_ROT  = 4'b0100,
        ST_DONE = 4'b1000
    } t_tilt_state;

    t_tilt_state r_state, n_state;

    logic [47:0] r_rem, r_res, r_bit;
    logic signed [16:0] r_num;
    logic signed [icf_pkg::CORD_W-1:0] r_x, r_y;
    logic signed [icf_pkg::TILT_W-1:0] r_z, r_tilt;
    logic [icf_pkg::CORDIC_IW-1:0] r_i;
    logic r_zero;

    logic signed [31:0] w_sqa, w_sqb;
    logic [31:0] w_sum;
    logic [47:0] w_trial, n_rem, n_res;
    logic signed [icf_pkg::CORD_W-1:0] w_xs, w_ys, w_y0;
    logic signed [icf_pkg::TILT_W-1:0] w_atan;

    assign w_sqa   = i_a * i_a;
    assign w_sqb   = i_b * i_b;
    assign w_sum   = $unsigned(w_sqa) + $unsigned(w_sqb);
    assign w_trial = r_res + r_bit;
    assign w_xs    = r_x >>> r_i;
    assign w_ys    = r_y >>> r_i;
    assign w_y0    = icf_pkg::CORD_W'(r_num) <<< 8;
    assign w_atan  = icf_pkg::atan_entry(5'(r_i));

    always_comb begin
        if (r_rem >= w_trial) begin
            n_rem = r_rem - w_trial;
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_rem = r_rem;
            n_res = r_res >> 1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: n_state = r_state;
            ST_SQRT: if (r_bit[0]) n_state = ST_ROT;
            ST_ROT:  if (r_i == icf_pkg::CORDIC_IW'(icf_pkg::CORDIC_STEPS - 1)) n_state = ST_DONE;
            ST_DONE: n_state = r_state;
            default: n_state = ST_IDLE;
        endcase
        if (i_start) n_state = ST_SQRT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {w_sum, 16'b0};
            r_res <= '0;
            r_bit <= 48'h1 << 46;
            r_num <= i_num;
        end else if (r_state == ST_SQRT) begin
            r_rem <= n_rem;
            r_res <= n_res;
            r_bit <= r_bit >> 2;
            if (r_bit[0]) begin
                r_x    <= signed'(n_res[icf_pkg::CORD_W-1:0]);
                r_y    <= w_y0;
                r_z    <= '0;
                r_i    <= '0;
                r_zero <= (n_res == 48'd0) && (r_num == 17'sd0);
            end
        end else if (r_state == ST_ROT) begin
            if (r_y > 0) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end
            r_i <= r_i + 1'b1;
            if (r_i == icf_pkg::CORDIC_IW'(icf_pkg::CORDIC_STEPS - 1)) begin
                r_tilt <= r_zero ? '0 : ((r_y > 0) ? r_z + w_atan : r_z - w_atan);
            end
        end
    end

    assign o_done = (r_state == ST_DONE);
    assign o_tilt = r_tilt;

endmodule

FILE: rtl/icf_gyro_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icf_gyro_lane
// Integrates one gyro rate over the time step: angle + round(rate*dt/15625).
// The division folds the upper dividend bits down three times and finishes
// with a reciprocal multiply.
// ----------------------------------------------------------------------------
module icf_gyro_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [15:0]  i_rate,
    input  logic [31:0]         i_dt,
    input  logic [31:0]         i_angle,
    output logic                o_done,
    output logic [31:0]         o_angle
);

    // 2^24 = 1073 * 15625 + 11591, so the upper 24 bits of the dividend can be
    // folded into the lower part while their quotient share is collected.
    localparam logic [10:0] FOLD_Q    = 11'd1073;
    localparam logic [13:0] FOLD_R    = 14'd11591;
    localparam logic [47:0] HALF_DIV  = 48'd7812;
    // ceil(2^39 / 15625); exact for every dividend below 2^25.
    localparam logic [25:0] RECIP     = 26'd35184373;
    // Three folds bring any dividend below 2^25.
    localparam logic [1:0]  LAST_FOLD = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_FOLD = 5'b00010,
        ST_FIN  = 5'b00100,
        ST_OUT  = 5'b01000,
        ST_DONE = 5'b10000
    } t_gyro_state;

    t_gyro_state r_state, n_state;

    logic [47:0] r_num;
    logic [31:0] r_q, r_ang, r_out;
    logic [1:0]  r_cnt;
    logic        r_neg;

    logic signed [48:0] w_prod;
    logic [47:0] w_mag;
    logic [23:0] w_hi, w_lo;
    logic [37:0] w_hi_r;
    logic [34:0] w_hi_q;
    logic [47:0] w_fold;
    logic [50:0] w_recip;
    logic [31:0] w_inc;

    assign w_prod  = i_rate * signed'({1'b0, i_dt});
    assign w_mag   = w_prod[48] ? 48'(-w_prod) : w_prod[47:0];
    assign w_hi    = r_num[47:24];
    assign w_lo    = r_num[23:0];
    assign w_hi_r  = w_hi * FOLD_R;
    assign w_hi_q  = w_hi * FOLD_Q;
    assign w_fold  = {10'd0, w_hi_r} + {24'd0, w_lo};
    assign w_recip = r_num[24:0] * RECIP;
    assign w_inc   = r_neg ? (32'd0 - r_q) : r_q;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: n_state = r_state;
            ST_FOLD: if (r_cnt == LAST_FOLD) n_state = ST_FIN;
            ST_FIN:  n_state = ST_OUT;
            ST_OUT:  n_state = ST_DONE;
            ST_DONE: n_state = r_state;
            default: n_state = ST_IDLE;
        endcase
        if (i_start) n_state = ST_FOLD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= w_mag + HALF_DIV;
            r_q   <= '0;
            r_cnt <= '0;
            r_neg <= w_prod[48];
            r_ang <= i_angle;
        end else if (r_state == ST_FOLD) begin
            r_num <= w_fold;
            r_q   <= r_q + w_hi_q[31:0];
            r_cnt <= r_cnt + 1'b1;
        end else if (r_state == ST_FIN) begin
            r_q <= r_q + {20'd0, w_recip[50:39]};
        end else if (r_state == ST_OUT) begin
            r_out <= r_ang + w_inc;
        end
    end

    assign o_done  = (r_state == ST_DONE);
    assign o_angle = r_out;

endmodule
